[rtl/sem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the sobel edge map with integral block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 12;
    localparam int THR_W      = 8;
    localparam int POS_W      = 11;
    localparam int INT_W      = 22;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int LINE_DEPTH = 2 ** POS_W;
    localparam int GRAD_W     = PIX_W + 4;
    localparam int SUM_W      = PIX_W + 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
    localparam logic [THR_W-1:0]  THR_RESET    = THR_W'(64);
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_EDGE_THRESHOLD = 2'd2
    } sem_cfg_idx_t;

    typedef logic [PIX_W-1:0] pix_t;

    // [row: top, mid, bottom][col: left, mid, right]
    typedef logic [2:0][2:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic             valid;
        logic             interior;
        logic             row_start;
        logic             top_row;
        logic             last;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] line;
    } sem_ctl_t;

endpackage

[rtl/sem_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pix_if
// Pixel request channel: valid, ready and one raster pixel.
// ----------------------------------------------------------------------------
interface sem_pix_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

[rtl/sem_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_res_if
// Result request channel: edge bit, edge integral and centre position.
// ----------------------------------------------------------------------------
interface sem_res_if
    import sem_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             edge_res;
    logic [INT_W-1:0] edge_integral;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] line;
    logic             last_of_frame;

    modport source (output valid, output edge_res, output edge_integral, output col,
                    output line, output last_of_frame, input ready);
    modport sink   (input valid, input edge_res, input edge_integral, input col,
                    input line, input last_of_frame, output ready);
endinterface

[rtl/sem_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sem_window.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_window
// Two line stores in one RAM word plus the 3x3 window registers.
// ----------------------------------------------------------------------------
module sem_window
    import sem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  sem_ctl_t         in_ctl,
    input  logic [POS_W-1:0] in_c,
    input  pix_t             in_px,
    output win_t             win,
    output sem_ctl_t         out_ctl
);

    sem_ctl_t             ctl1_reg;
    sem_ctl_t             ctl2_reg;
    logic [POS_W-1:0]     c1_reg;
    pix_t                 px1_reg;
    logic                 fwd_valid_reg;
    logic                 fwd_valid_next;
    logic [2*PIX_W-1:0]   fwd_data_reg;
    win_t                 win_reg;
    win_t                 win_next;
    logic [2*PIX_W-1:0]   ram_q;
    logic [2*PIX_W-1:0]   line_word;
    logic [2*PIX_W-1:0]   wr_word;
    pix_t                 up_px;
    pix_t                 mid_px;
    logic                 wr_en;

    // word layout: upper line in the high byte, middle line in the low byte
    sem_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (c1_reg),
        .wdata (wr_word),
        .re    (adv),
        .raddr (in_c),
        .rdata (ram_q)
    );

    // the previous pixel may have written this column in the read cycle
    always_comb
    begin
        line_word      = fwd_valid_reg ? fwd_data_reg : ram_q;
        up_px          = line_word[2*PIX_W-1:PIX_W];
        mid_px         = line_word[PIX_W-1:0];
        wr_word        = {mid_px, px1_reg};
        wr_en          = adv && ctl1_reg.valid;
        fwd_valid_next = ctl1_reg.valid && (c1_reg == in_c);
    end

    always_comb
    begin
        win_next = win_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = up_px;
        win_next[1][2] = mid_px;
        win_next[2][2] = px1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg      <= '0;
            ctl2_reg      <= '0;
            fwd_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else if (adv)
        begin
            ctl1_reg      <= in_ctl;
            ctl2_reg      <= ctl1_reg;
            fwd_valid_reg <= fwd_valid_next;
            if (ctl1_reg.valid)
            begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg       <= in_c;
            px1_reg      <= in_px;
            fwd_data_reg <= wr_word;
        end
    end

    assign win     = win_reg;
    assign out_ctl = ctl2_reg;

endmodule

[rtl/sem_sobel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_sobel
// Sobel gradients over the window, L1 magnitude against the threshold.
// ----------------------------------------------------------------------------
module sem_sobel
    import sem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  win_t             win,
    input  sem_ctl_t         in_ctl,
    input  logic [THR_W-1:0] thr,
    output sem_ctl_t         out_ctl,
    output logic             edge_bit
);

    sem_ctl_t                  ctl_reg;
    logic                      edge_reg;
    logic                      edge_next;
    logic [SUM_W-1:0]          sum_top;
    logic [SUM_W-1:0]          sum_bot;
    logic [SUM_W-1:0]          sum_left;
    logic [SUM_W-1:0]          sum_right;
    logic signed [GRAD_W-1:0]  gx;
    logic signed [GRAD_W-1:0]  gy;
    logic [GRAD_W-1:0]         abs_gx;
    logic [GRAD_W-1:0]         abs_gy;
    logic [GRAD_W-1:0]         mag;

    function automatic logic [SUM_W-1:0] wsum(input pix_t a, input pix_t b, input pix_t c);
        wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
    endfunction

    always_comb
    begin
        sum_top   = wsum(win[0][0], win[0][1], win[0][2]);
        sum_bot   = wsum(win[2][0], win[2][1], win[2][2]);
        sum_left  = wsum(win[0][0], win[1][0], win[2][0]);
        sum_right = wsum(win[0][2], win[1][2], win[2][2]);
        gx        = $signed({2'b00, sum_top}) - $signed({2'b00, sum_bot});
        gy        = $signed({2'b00, sum_left}) - $signed({2'b00, sum_right});
        abs_gx    = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
        abs_gy    = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
        mag       = abs_gx + abs_gy;
        edge_next = mag > GRAD_W'(thr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge_reg <= edge_next;
        end
    end

    assign out_ctl  = ctl_reg;
    assign edge_bit = edge_reg;

endmodule

[rtl/sem_integral.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_integral
// Running row count of edges plus the integral line store, result register.
// ----------------------------------------------------------------------------
module sem_integral
    import sem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  sem_ctl_t  rd_ctl,
    input  sem_ctl_t  in_ctl,
    input  logic      edge_bit,
    sem_res_if.source res
);

    logic [POS_W-1:0] row_sum_reg;
    logic [POS_W-1:0] row_sum_next;
    logic [INT_W-1:0] above;
    logic [INT_W-1:0] total;
    logic [INT_W-1:0] ram_q;
    logic             take;
    logic             res_valid_reg;
    logic             edge_out_reg;
    logic [INT_W-1:0] integral_out_reg;
    logic [POS_W-1:0] col_out_reg;
    logic [POS_W-1:0] line_out_reg;
    logic             last_out_reg;

    // read in the stage before, so the word is ready when the edge bit is
    sem_ram #(
        .WIDTH (INT_W),
        .DEPTH (LINE_DEPTH)
    ) u_int_ram (
        .clk   (clk),
        .we    (take),
        .waddr (in_ctl.col),
        .wdata (total),
        .re    (adv),
        .raddr (rd_ctl.col),
        .rdata (ram_q)
    );

    always_comb
    begin
        take         = adv && in_ctl.valid && in_ctl.interior;
        row_sum_next = in_ctl.row_start ? POS_W'(edge_bit)
                                        : row_sum_reg + POS_W'(edge_bit);
        // first interior row has nothing above it
        above        = in_ctl.top_row ? '0 : ram_q;
        total        = INT_W'(row_sum_next) + above;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= in_ctl.valid && in_ctl.interior;
            if (take)
            begin
                row_sum_reg <= row_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            edge_out_reg     <= edge_bit;
            integral_out_reg <= total;
            col_out_reg      <= in_ctl.col;
            line_out_reg     <= in_ctl.line;
            last_out_reg     <= in_ctl.last;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.edge_res      = edge_out_reg;
    assign res.edge_integral = integral_out_reg;
    assign res.col           = col_out_reg;
    assign res.line          = line_out_reg;
    assign res.last_of_frame = last_out_reg;

endmodule

[rtl/sobel_edge_map_with_integral_unit.sv]
`timescale 1ns / 1ps
// path: window input register, window register, Sobel register, then result register
// throughput: one pixel per clock, set by the one read and one write port per cycle of the
//   line store RAM and the integral RAM (same-column writes are forwarded)
// all stages stall together while a result waits for ready
// reset: counters, window, row count and config registers to defaults; RAMs are not cleared
// ----------------------------------------------------------------------------
// sobel_edge_map_with_integral_unit
// Raster Sobel edge map with a summed-area count of edge pixels.
// ----------------------------------------------------------------------------
module sobel_edge_map_with_integral_unit
    import sem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    sem_pix_if.sink              pix,
    sem_res_if.source            res
);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [POS_W-1:0]  col_cnt_reg;
    logic [POS_W-1:0]  col_cnt_next;
    logic [POS_W-1:0]  row_cnt_reg;
    logic [POS_W-1:0]  row_cnt_next;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [POS_W-1:0]  c0;
    logic [POS_W-1:0]  r0;
    logic [SIZE_W-1:0] c0_x;
    logic [SIZE_W-1:0] r0_x;
    logic              adv;
    logic              accept;
    sem_ctl_t          ctl0;
    sem_ctl_t          ctl2;
    sem_ctl_t          ctl3;
    win_t              win;
    logic              edge_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= THR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                CFG_EDGE_THRESHOLD: thr_reg    <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = (width_reg < SIZE_MIN) ? SIZE_MIN :
                (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
        h_eff = (height_reg < SIZE_MIN) ? SIZE_MIN :
                (height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg;
    end

    assign adv       = !res.valid || res.ready;
    assign pix.ready = adv;
    assign accept    = pix.valid && adv;

    always_comb
    begin
        c0   = pix.frame_start ? '0 : col_cnt_reg;
        r0   = pix.frame_start ? '0 : row_cnt_reg;
        c0_x = {1'b0, c0};
        r0_x = {1'b0, r0};

        ctl0.valid     = accept;
        ctl0.interior  = (c0 >= POS_W'(2)) && (c0_x < w_eff)
                      && (r0 >= POS_W'(2)) && (r0_x < h_eff);
        ctl0.row_start = (c0 == POS_W'(2));
        ctl0.top_row   = (r0 == POS_W'(2));
        ctl0.last      = (c0_x == w_eff - SIZE_W'(1)) && (r0_x == h_eff - SIZE_W'(1));
        ctl0.col       = c0 - POS_W'(1);
        ctl0.line      = r0 - POS_W'(1);

        // a counter beyond a reduced size also wraps here
        if (c0_x + SIZE_W'(1) >= w_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r0_x + SIZE_W'(1) >= h_eff) ? '0 : r0 + POS_W'(1);
        end
        else
        begin
            col_cnt_next = c0 + POS_W'(1);
            row_cnt_next = r0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    sem_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_ctl  (ctl0),
        .in_c    (c0),
        .in_px   (pix.pixel),
        .win     (win),
        .out_ctl (ctl2)
    );

    sem_sobel u_sobel (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .win      (win),
        .in_ctl   (ctl2),
        .thr      (thr_reg),
        .out_ctl  (ctl3),
        .edge_bit (edge_bit)
    );

    sem_integral u_integral (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .rd_ctl   (ctl2),
        .in_ctl   (ctl3),
        .edge_bit (edge_bit),
        .res      (res)
    );

endmodule

[tb/edge_integral_board.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_integral_board
// Predicts the edge bit and the edge-count integral of every accepted interior
// pixel and checks the results of the block against them in arrival order.
// ----------------------------------------------------------------------------
class edge_integral_board;

    typedef struct {
        bit                      is_edge;
        bit [sem_pkg::INT_W-1:0] total;
        bit [sem_pkg::POS_W-1:0] col;
        bit [sem_pkg::POS_W-1:0] line;
        bit                      last;
    } edge_count_t;

    localparam int MAX_REPORTS = 10;

    bit [sem_pkg::PIX_W-1:0]  upper_row   [sem_pkg::MAX_WIDTH];
    bit [sem_pkg::PIX_W-1:0]  middle_row  [sem_pkg::MAX_WIDTH];
    bit [sem_pkg::INT_W-1:0]  integral_row[sem_pkg::MAX_WIDTH];
    // [row: top, mid, bottom][col: left, mid, right]
    bit [sem_pkg::PIX_W-1:0]  win[3][3];
    int unsigned              col_cnt;
    int unsigned              row_cnt;
    bit [12:0]                row_sum;
    bit [sem_pkg::SIZE_W-1:0] width_reg;
    bit [sem_pkg::SIZE_W-1:0] height_reg;
    bit [sem_pkg::THR_W-1:0]  thr_reg;
    edge_count_t              pending_edges[$];
    int                       errors;

    function new();
        width_reg  = sem_pkg::WIDTH_RESET;
        height_reg = sem_pkg::HEIGHT_RESET;
        thr_reg    = sem_pkg::THR_RESET;
        col_cnt    = 0;
        row_cnt    = 0;
        row_sum    = '0;
        errors     = 0;
    endfunction

    static function int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v < 3)
        begin
            return 3;
        end
        return (v > hi) ? hi : v;
    endfunction

    function int unsigned cols();
        return clamp_size(width_reg, sem_pkg::MAX_WIDTH);
    endfunction

    function int unsigned rows();
        return clamp_size(height_reg, sem_pkg::MAX_HEIGHT);
    endfunction

    function void set_register(logic [sem_pkg::CFG_IDX_W-1:0] index,
                               logic [sem_pkg::SIZE_W-1:0] value);
        case (index)
            sem_pkg::CFG_IMAGE_WIDTH:    width_reg  = value;
            sem_pkg::CFG_IMAGE_HEIGHT:   height_reg = value;
            sem_pkg::CFG_EDGE_THRESHOLD: thr_reg    = value[sem_pkg::THR_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_pixel(bit [sem_pkg::PIX_W-1:0] px, bit fs);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned centre;
        int unsigned centre_line;
        int          gx;
        int          gy;
        int          mag;
        edge_count_t e;

        w = cols();
        h = rows();
        if (fs)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        c = col_cnt % sem_pkg::MAX_WIDTH;
        r = row_cnt;

        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2]     = upper_row[c];
        win[1][2]     = middle_row[c];
        win[2][2]     = px;
        upper_row[c]  = win[1][2];
        middle_row[c] = px;

        if (c >= 2 && c < w && r >= 2 && r < h)
        begin
            gx = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
               - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
            gy = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
               - int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            e.is_edge = (mag > int'(thr_reg));
            if (c == 2)
            begin
                row_sum = '0;
            end
            row_sum = row_sum + e.is_edge;
            // nothing from above on the first interior row
            e.total = row_sum + ((r == 2) ? '0 : integral_row[c-1]);
            integral_row[c-1] = e.total;
            centre      = c - 1;
            centre_line = r - 1;
            e.col  = centre[sem_pkg::POS_W-1:0];
            e.line = centre_line[sem_pkg::POS_W-1:0];
            e.last = (c == w - 1) && (r == h - 1);
            pending_edges.push_back(e);
        end

        if (c + 1 >= w)
        begin
            col_cnt = 0;
            row_cnt = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_cnt = c + 1;
        end
    endfunction

    function void match_result(logic is_edge, logic [sem_pkg::INT_W-1:0] total,
                               logic [sem_pkg::POS_W-1:0] col,
                               logic [sem_pkg::POS_W-1:0] line, logic last);
        edge_count_t want;

        if (pending_edges.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("unexpected result: edge=%0d integral=%0d col=%0d line=%0d last=%0d",
                         is_edge, total, col, line, last);
            end
            return;
        end
        want = pending_edges.pop_front();
        if (is_edge !== want.is_edge || total !== want.total || col !== want.col ||
            line !== want.line || last !== want.last)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("mismatch: expected edge=%0d integral=%0d col=%0d line=%0d last=%0d",
                         want.is_edge, want.total, want.col, want.line, want.last);
                $display("          actual   edge=%0d integral=%0d col=%0d line=%0d last=%0d",
                         is_edge, total, col, line, last);
            end
        end
    endfunction

endclass

[tb/tb_sobel_edge_map_with_integral_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_map_with_integral_unit
// Streams raster frames through the edge map block: the first pixels at the
// reset size, short directed frames, the first lines of the widest and
// tallest frames, then random small frames with resized continuations, stray
// frame starts and cut frames.
// The sender runs in bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_sobel_edge_map_with_integral_unit;
    import sem_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int RANDOM_ITEMS   = 520;
    localparam int COVER_WIDTH    = 40;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 250;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {TEX_NOISE, TEX_SOFT, TEX_BINARY, TEX_FLAT} texture_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;

    sem_pix_if pix();
    sem_res_if res();

    edge_integral_board sb = new();
    int burst_left       = 0;
    int holdoffs_asked   = 0;
    int holdoffs_granted = 0;

    sobel_edge_map_with_integral_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .res       (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic bit [PIX_W-1:0] shade(texture_t style, bit [PIX_W-1:0] base);
        int v;

        case (style)
            TEX_NOISE:  v = int'($urandom_range(0, 255));
            TEX_SOFT:   v = int'(base) + int'($urandom_range(0, 24)) - 12;
            TEX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
            default:    v = int'(base);
        endcase
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > 255)
        begin
            v = 255;
        end
        return v[PIX_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_register(index, value);
    endtask

    task automatic apply_settings(input int unsigned w, input int unsigned h,
                                  input bit [THR_W-1:0] thr, input bit [3:0] which);
        if (which[0])
        begin
            write_reg(CFG_IMAGE_WIDTH, SIZE_W'(w));
        end
        if (which[1])
        begin
            write_reg(CFG_IMAGE_HEIGHT, SIZE_W'(h));
        end
        if (which[2])
        begin
            // upper data bits are junk for the threshold
            write_reg(CFG_EDGE_THRESHOLD, {4'($urandom), thr});
        end
        if (which[3])
        begin
            write_reg(CFG_SPARE, SIZE_W'($urandom));
        end
        cfg_we <= 1'b0;
    endtask

    // one pixel request, with a random gap whenever the burst runs out
    task automatic offer(input bit [PIX_W-1:0] px, input bit fs);
        if (burst_left == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(0, 5) == 0 ? $urandom_range(7, 20) : $urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        pix.valid       <= 1'b1;
        pix.pixel       <= px;
        pix.frame_start <= fs;
        do
            @(posedge clk);
        while (pix.ready !== 1'b1);
        sb.take_pixel(px, fs);
    endtask

    task automatic send_frame(input bit open_fs, input int unsigned count, input bit stray);
        int unsigned      w;
        int unsigned      stray_at;
        texture_t         style;
        bit [PIX_W-1:0]   base;

        w        = sb.cols();
        stray_at = (stray && count > 2) ? $urandom_range(1, count - 1) : count;
        style    = TEX_NOISE;
        base     = '0;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k % w == 0)
            begin
                style = texture_t'($urandom_range(0, 3));
                base  = PIX_W'($urandom_range(0, 255));
            end
            offer(shade(style, base), (k == 0 && open_fs) || k == stray_at);
        end
    endtask

    // idle until every expected result is in and the pipeline has emptied
    task automatic settle();
        pix.valid <= 1'b0;
        while (sb.pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
        begin
            sb.match_result(res.edge_res, res.edge_integral, res.col, res.line,
                            res.last_of_frame);
        end
    end

    // receiver stall pattern, with long hold-offs on request
    initial
    begin
        int       run_left;
        int       hold_left;
        int       tick;
        rx_mode_t mode;

        run_left  = 0;
        hold_left = 0;
        tick      = 0;
        mode      = RX_OPEN;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (holdoffs_granted != holdoffs_asked)
            begin
                holdoffs_granted++;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode     = rx_mode_t'($urandom_range(0, 2));
                    run_left = $urandom_range(10, 150);
                end
                run_left--;
                case (mode)
                    RX_OPEN: res.ready <= 1'b1;
                    RX_COIN: res.ready <= 1'($urandom_range(0, 1));
                    default: res.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        int quiet;

        quiet = 0;
        @(posedge rst_n);
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
                (res.valid === 1'b1 && res.ready === 1'b1))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          random_items;
        int          frames;
        int unsigned count;
        int unsigned w_val;
        int unsigned h_val;
        int unsigned pick;
        bit [7:0]    thr_val;
        bit [3:0]    which;
        bit          carry_on;

        random_items    = 0;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_IMAGE_WIDTH;
        cfg_data        <= '0;
        pix.valid       <= 1'b0;
        pix.pixel       <= '0;
        pix.frame_start <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes and threshold: the first pixels of the default frame
        send_frame(1'b1, 64, 1'b0);
        settle();

        // flat frame at threshold zero, then a frame with no frame start
        apply_settings(3, 3, 8'd0, 4'b0111);
        for (int k = 0; k < 9; k++)
            offer(8'd0, k == 0);
        for (int k = 0; k < 9; k++)
            offer((k < 3) ? 8'd255 : 8'd0, 1'b0);
        settle();
        // sizes below the minimum, top threshold, unused register index
        apply_settings(0, 2, 8'd255, 4'b1111);
        for (int k = 0; k < 9; k++)
            offer((k % 3 == 0) ? 8'd255 : 8'd0, k == 0);
        settle();

        // widest frame, cut after its first pixels
        apply_settings(4095, 3, 8'($urandom), 4'b0111);
        send_frame(1'b1, 64, 1'b0);
        settle();
        // tallest frame, cut, with the receiver holding off so the block fills up
        apply_settings(3, 4095, 8'd128, 4'b0111);
        holdoffs_asked++;
        send_frame(1'b1, 48, 1'b0);
        settle();
        // writes every column that the random frames below can reach
        apply_settings(COVER_WIDTH, 3, 8'($urandom), 4'b0111);
        send_frame(1'b1, 3 * COVER_WIDTH, 1'b0);
        settle();

        while (random_items < RANDOM_ITEMS)
        begin
            pick  = $urandom_range(0, 19);
            w_val = (pick == 0) ? $urandom_range(0, 2) :
                    (pick < 14) ? $urandom_range(3, 10) : $urandom_range(11, COVER_WIDTH);
            h_val = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 2)
                                                 : $urandom_range(3, 8);
            pick    = $urandom_range(0, 7);
            thr_val = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
            which   = 4'($urandom);
            apply_settings(w_val, h_val, thr_val, which);
            if ($urandom_range(0, 5) == 0)
            begin
                holdoffs_asked++;
            end
            // sometimes pick up the counters where the last phase left them
            carry_on = ($urandom_range(0, 4) == 0);
            frames   = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                count = sb.cols() * sb.rows();
                if ($urandom_range(0, 7) == 0)
                begin
                    count = $urandom_range(1, count - 1);
                end
                send_frame((f == 0) ? !carry_on : 1'($urandom_range(0, 1)), count,
                           $urandom_range(0, 5) == 0);
                random_items += count;
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending_edges.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sem_pkg.sv
rtl/sem_pix_if.sv
rtl/sem_res_if.sv
rtl/sem_ram.sv
rtl/sem_window.sv
rtl/sem_sobel.sv
rtl/sem_integral.sv
rtl/sobel_edge_map_with_integral_unit.sv
tb/edge_integral_board.sv
tb/tb_sobel_edge_map_with_integral_unit.sv
